@@ rtl/gle_pkg.sv @@
// Shared types, constants and helpers of the GIF LZW encoder.
package gle_pkg;

    localparam int HASH_SLOTS_DEF = 8192;
    localparam logic [12:0] LZW_LIMIT = 13'hfff;
    localparam logic [8:0] SMALL_CLEAR = 9'h4;
    localparam logic [15:0] HASH_MULT = 16'd40503;
    localparam logic [3:0] DEPTH_RESET = 4'd8;

    typedef struct packed {
        logic [7:0] pixel;
        logic       last_pixel;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out_word;

    typedef struct packed {
        logic        used;
        logic [11:0] pre;
        logic [7:0]  pix;
        logic [11:0] code;
    } t_entry;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_START, S_LOOK, S_READ, S_CMP, S_EMIT,
        S_CLRC, S_WIPE, S_TAIL, S_FIN1, S_FIN2, S_FIN3
    } t_state;

    typedef enum logic [1:0] {
        PUT_CLEAR, PUT_PREFIX, PUT_EOI
    } t_put_sel;

    typedef struct packed {
        logic     accept;
        logic     put;
        t_put_sel put_sel;
        logic     start_set;
        logic     set_first;
        logic     hash;
        logic     probe;
        logic     insert;
        logic     found;
        logic     bump;
        logic     dict_reset;
        logic     pix_prefix;
        logic     wipe;
        logic     restart;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic started;
        logic pvalid;
        logic hit;
        logic empty;
        logic wipe_last;
        logic at_limit;
        logic last;
    } t_sts;

    function automatic logic [3:0] eff_depth(input logic [3:0] d);
        if (d < 4'd2) begin
            return 4'd2;
        end else if (d > 4'd8) begin
            return 4'd8;
        end
        return d;
    endfunction

    function automatic logic [8:0] clear_code(input logic [3:0] d);
        logic [3:0] e;
        e = eff_depth(d);
        if (e == 4'd2) begin
            return SMALL_CLEAR;
        end
        return 9'd1 << e;
    endfunction

endpackage

@@ rtl/gle_ctrl.sv @@
// Sequencing state machine of the GIF LZW encoder.
module gle_ctrl
    import gle_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_cfg_we,
    input  t_sts   i_sts,
    output logic   o_in_ready,
    output t_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT:  if (i_sts.wipe_last) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_START;
            S_START: if (i_sts.started || !i_sts.busy) n_state = S_LOOK;
            S_LOOK:  n_state = i_sts.pvalid ? S_READ : S_TAIL;
            S_READ:  n_state = S_CMP;
            S_CMP: begin
                if (i_sts.hit) begin
                    n_state = S_TAIL;
                end else if (i_sts.empty) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_EMIT:  if (!i_sts.busy) n_state = i_sts.at_limit ? S_CLRC : S_TAIL;
            S_CLRC:  if (!i_sts.busy) n_state = S_WIPE;
            S_WIPE:  if (i_sts.wipe_last) n_state = S_TAIL;
            S_TAIL:  n_state = i_sts.last ? S_FIN1 : S_IDLE;
            S_FIN1:  if (!i_sts.busy) n_state = S_FIN2;
            S_FIN2:  if (!i_sts.busy) n_state = S_FIN3;
            S_FIN3:  if (!i_sts.busy) n_state = S_INIT;
            default: n_state = S_INIT;
        endcase
        if (i_cfg_we) begin
            n_state = S_INIT;
        end
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.put_sel = PUT_CLEAR;
        o_in_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.wipe = 1'b1;
                o_cmd.restart = i_sts.wipe_last;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_START: begin
                if (!i_sts.started && !i_sts.busy) begin
                    o_cmd.put = 1'b1;
                    o_cmd.start_set = 1'b1;
                end
            end
            S_LOOK: begin
                o_cmd.set_first = !i_sts.pvalid;
                o_cmd.hash = i_sts.pvalid;
            end
            S_READ: ;
            S_CMP: begin
                o_cmd.found = i_sts.hit;
                o_cmd.insert = !i_sts.hit && i_sts.empty;
                o_cmd.probe = !i_sts.hit && !i_sts.empty;
            end
            S_EMIT: begin
                if (!i_sts.busy) begin
                    o_cmd.put = 1'b1;
                    o_cmd.put_sel = PUT_PREFIX;
                    o_cmd.bump = 1'b1;
                    o_cmd.pix_prefix = !i_sts.at_limit;
                end
            end
            S_CLRC: begin
                if (!i_sts.busy) begin
                    o_cmd.put = 1'b1;
                    o_cmd.dict_reset = 1'b1;
                    o_cmd.pix_prefix = 1'b1;
                end
            end
            S_WIPE: o_cmd.wipe = 1'b1;
            S_TAIL: ;
            S_FIN1: begin
                o_cmd.put = !i_sts.busy;
                o_cmd.put_sel = PUT_PREFIX;
            end
            S_FIN2: begin
                o_cmd.put = !i_sts.busy;
                o_cmd.put_sel = PUT_EOI;
            end
            S_FIN3: ;
            default: ;
        endcase
    end

endmodule

@@ rtl/gle_datapath.sv @@
// Dictionary memory, hash, code state and bit packer of the GIF LZW encoder.
module gle_datapath
    import gle_pkg::*;
#(
    parameter int HASH_SLOTS = HASH_SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_word,
    input  logic      i_cfg_we,
    input  logic [3:0] i_cfg_data,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int HB = $clog2(HASH_SLOTS);

    t_entry r_mem [HASH_SLOTS];
    t_entry r_rd;

    logic [3:0]    r_depth;
    logic [7:0]    r_pix;
    logic          r_last;
    logic [11:0]   r_prefix;
    logic          r_pvalid;
    logic [12:0]   r_nfc;
    logic [3:0]    r_cw;
    logic          r_started;
    logic [HB-1:0] r_slot;
    logic [HB-1:0] r_wcnt;
    logic [19:0]   r_acc;
    logic [4:0]    r_nb;
    logic          r_final;
    logic          r_ov;
    t_out_word     r_out;

    logic [8:0]  cc;
    logic [3:0]  cw0;
    logic [11:0] put_code;
    logic [12:0] wmask;
    logic [35:0] prod;
    logic        slot_free;
    logic        byte_load;

    assign cc = clear_code(r_depth);
    assign cw0 = eff_depth(r_depth) + 4'd1;
    assign wmask = (13'd1 << r_cw) - 13'd1;
    assign prod = 36'({r_prefix, r_pix}) * 36'(HASH_MULT);
    assign slot_free = !r_ov || i_out_ready;
    assign byte_load = !i_cmd.restart && !i_cmd.put && slot_free &&
                       ((r_nb >= 5'd8) || (r_final && r_nb != 5'd0));

    always_comb begin
        case (i_cmd.put_sel)
            PUT_CLEAR:  put_code = {3'd0, cc};
            PUT_PREFIX: put_code = r_prefix;
            PUT_EOI:    put_code = {3'd0, cc + 9'd1};
            default:    put_code = r_prefix;
        endcase
    end

    // dictionary: one write port, registered read at the probe slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.wipe) begin
            r_mem[r_wcnt] <= '0;
        end else if (i_cmd.insert) begin
            r_mem[r_slot] <= '{used: 1'b1, pre: r_prefix, pix: r_pix, code: r_nfc[11:0]};
        end
        r_rd <= r_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= DEPTH_RESET;
            r_wcnt <= '0;
        end else begin
            if (i_cfg_we) begin
                r_depth <= i_cfg_data;
                r_wcnt <= '0;
            end else if (i_cmd.wipe) begin
                r_wcnt <= r_wcnt + HB'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix <= i_in_word.pixel & 8'(cc - 9'd1);
            r_last <= i_in_word.last_pixel;
        end
        if (i_cmd.hash) begin
            r_slot <= prod[HB-1:0];
        end else if (i_cmd.probe) begin
            r_slot <= r_slot + HB'(1);
        end
        if (i_cmd.restart) begin
            r_prefix <= '0;
        end else if (i_cmd.found) begin
            r_prefix <= r_rd.code;
        end else if (i_cmd.set_first || i_cmd.pix_prefix) begin
            r_prefix <= {4'd0, r_pix};
        end
        if (i_cmd.restart || i_cmd.dict_reset) begin
            r_nfc <= {4'd0, cc} + 13'd2;
            r_cw <= cw0;
        end else if (i_cmd.bump) begin
            r_nfc <= r_nfc + 13'd1;
            if (r_nfc == (13'd1 << r_cw)) begin
                r_cw <= r_cw + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_pvalid <= 1'b0;
            r_started <= 1'b0;
        end else begin
            if (i_cmd.set_first) r_pvalid <= 1'b1;
            if (i_cmd.start_set) r_started <= 1'b1;
        end
    end

    // bit packer and output register; one byte leaves per cycle while the receiver is ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_nb <= '0;
            r_final <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_ov <= byte_load || (r_ov && !i_out_ready);
            if (i_cmd.restart) begin
                r_acc <= '0;
                r_nb <= '0;
                r_final <= 1'b0;
            end else if (i_cmd.put) begin
                r_acc <= r_acc | (20'(put_code & wmask[11:0]) << r_nb);
                r_nb <= r_nb + 5'(r_cw);
                r_final <= (i_cmd.put_sel == PUT_EOI);
            end else if (slot_free && r_nb >= 5'd8) begin
                r_out <= '{out_byte: r_acc[7:0], last_byte: r_final && r_nb == 5'd8};
                r_acc <= r_acc >> 8;
                r_nb <= r_nb - 5'd8;
            end else if (slot_free && r_final && r_nb != 5'd0) begin
                r_out <= '{out_byte: r_acc[7:0], last_byte: 1'b1};
                r_acc <= '0;
                r_nb <= '0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_word = r_out;

    assign o_sts.busy = (r_nb >= 5'd8) || (r_final && r_nb != 5'd0);
    assign o_sts.started = r_started;
    assign o_sts.pvalid = r_pvalid;
    assign o_sts.hit = r_rd.used && r_rd.pre == r_prefix && r_rd.pix == r_pix;
    assign o_sts.empty = !r_rd.used;
    assign o_sts.wipe_last = (r_wcnt == {HB{1'b1}});
    assign o_sts.at_limit = (r_nfc + 13'd1 == LZW_LIMIT);
    assign o_sts.last = r_last;

endmodule

@@ rtl/gif_lzw_encoder.sv @@
// Top level of the GIF LZW encoder: pixels in, packed code bytes out.
//
// Input channel (i_in_valid / o_in_ready) takes one word per pixel: palette
// index and an end-of-image flag. Output channel (o_out_valid / i_out_ready)
// gives the LZW code stream as bytes, codes packed LSB first, with
// last_byte set on the final (zero-padded) byte of each image.
// Each accepted pixel is hashed and looked up through the registered read
// of the dictionary, once more per extra hash probe; a miss emits a code;
// an image's first pixel skips the lookup. A code put waits while the packer
// still holds a full byte. The last pixel adds its final codes and the pad.
// The dictionary is wiped by a pass over all HASH_SLOTS slots after reset,
// after a pixel_depth write, after each image's last pixel and whenever the
// code space fills; no pixel is taken during the pass.
// Writing i_cfg_data (pixel_depth) restarts the stream with the new depth.
// When the receiver stalls, one byte waits in the output register and the
// packer holds further bytes; the next pixel is still taken and waits for
// the packer before it emits anything.
module gif_lzw_encoder
    import gle_pkg::*;
#(
    parameter int HASH_SLOTS = HASH_SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out_word,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    gle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cfg_we   (i_cfg_we),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    gle_datapath #(
        .HASH_SLOTS (HASH_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    a_put_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.put |-> !sts.busy)
        else $error("code put while packer still holds a full byte");

    a_insert_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.insert |-> (sts.empty && !sts.hit))
        else $error("dictionary insert into an occupied slot");

    a_no_accept_in_wipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wipe |-> !o_in_ready)
        else $error("pixel offered ready during dictionary wipe");

endmodule

@@ test/gle_checker.sv @@
// Scoreboard for the GIF LZW encoder: watches both channels, predicts bytes, compares.
`timescale 1ns / 100ps
module gle_checker
    import gle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_word   i_in_word,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_word  i_out_word,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data,
    output int         o_err_count,
    output int         o_pending
);

    logic [3:0]  depth_reg;
    logic [11:0] prefix;
    logic        prefix_ok;
    logic [12:0] next_code;
    logic [3:0]  code_bits;
    logic [7:0]  acc;
    logic [3:0]  bits_free;
    logic        started;
    logic [11:0] code_dict [logic [19:0]];
    t_out_word   byte_q [$];
    int          n_new;

    assign o_pending = byte_q.size();

    function automatic logic [3:0] depth_used(input logic [3:0] d);
        if (d < 4'd2) return 4'd2;
        if (d > 4'd8) return 4'd8;
        return d;
    endfunction

    function automatic logic [8:0] clr_of(input logic [3:0] d);
        logic [3:0] e;
        e = depth_used(d);
        return (e == 4'd2) ? 9'd4 : (9'd1 << e);
    endfunction

    task automatic report_err(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        o_err_count++;
    endtask

    task automatic restart_stream();
        code_dict.delete();
        prefix    = '0;
        prefix_ok = 1'b0;
        next_code = 13'(clr_of(depth_reg)) + 13'd2;
        code_bits = depth_used(depth_reg) + 4'd1;
        acc       = '0;
        bits_free = 4'd8;
        started   = 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] b);
        t_out_word w;
        w.out_byte  = b;
        w.last_byte = 1'b0;
        byte_q.push_back(w);
        n_new++;
    endtask

    // pack LSB first into the partial byte
    task automatic pack_code(input logic [11:0] code, input int n);
        int c;
        c = code;
        while (n >= bits_free) begin
            acc = acc | 8'((c & ((1 << bits_free) - 1)) << (8 - bits_free));
            push_byte(acc);
            acc = '0;
            c = c >> bits_free;
            n = n - bits_free;
            bits_free = 4'd8;
        end
        if (n > 0) begin
            acc = acc | 8'((c & ((1 << n) - 1)) << (8 - bits_free));
            bits_free = bits_free - 4'(n);
        end
    endtask

    task automatic predict_pixel(input t_in_word w);
        logic [8:0]  cc;
        logic [7:0]  pix;
        logic [19:0] key;
        cc    = clr_of(depth_reg);
        pix   = w.pixel & 8'(cc - 9'd1);
        n_new = 0;
        if (!started) begin
            pack_code(12'(cc), code_bits);
            started = 1'b1;
        end
        key = {prefix, pix};
        if (!prefix_ok) begin
            prefix    = 12'(pix);
            prefix_ok = 1'b1;
        end else if (code_dict.exists(key)) begin
            prefix = code_dict[key];
        end else begin
            code_dict[key] = next_code[11:0];
            pack_code(prefix, code_bits);
            if (next_code == (13'd1 << code_bits)) code_bits++;
            next_code++;
            if (next_code == 13'hfff) begin
                code_dict.delete();
                pack_code(12'(cc), code_bits);
                next_code = 13'(cc) + 13'd2;
                code_bits = depth_used(depth_reg) + 4'd1;
            end
            prefix = 12'(pix);
        end
        if (w.last_pixel) begin
            pack_code(prefix, code_bits);
            pack_code(12'(cc) + 12'd1, code_bits);
            if (bits_free < 4'd8) push_byte(acc);
            if (n_new > 0) byte_q[byte_q.size() - 1].last_byte = 1'b1;
            restart_stream();
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            o_err_count = 0;
            depth_reg = DEPTH_RESET;
            restart_stream();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (byte_q.size() == 0) begin
                    report_err($sformatf("unexpected word %h", i_out_word));
                end else begin
                    want = byte_q.pop_front();
                    if (i_out_word.out_byte !== want.out_byte)
                        report_err($sformatf("out_byte %h, want %h",
                                             i_out_word.out_byte, want.out_byte));
                    if (i_out_word.last_byte !== want.last_byte)
                        report_err($sformatf("last_byte %b, want %b",
                                             i_out_word.last_byte, want.last_byte));
                end
            end
            if (i_cfg_we) begin
                depth_reg = i_cfg_data;
                restart_stream();
            end else if (i_in_valid && i_in_ready) begin
                predict_pixel(i_in_word);
            end
        end
    end

endmodule

@@ test/tb_gif_lzw_encoder.sv @@
// Testbench top for the GIF LZW encoder: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module tb_gif_lzw_encoder;
    import gle_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in_word   in_word;
    logic       out_valid;
    logic       out_ready;
    t_out_word  out_word;
    logic       cfg_we;
    logic [3:0] cfg_data;
    int         err_count;
    int         pending;
    bit         gaps_on;
    bit         hold_go;

    gif_lzw_encoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    gle_checker u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in_ready (in_ready),
        .i_in_word  (in_word),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_out_word (out_word),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .o_err_count(err_count),
        .o_pending  (pending)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // every image ends with a dictionary wipe, so even short images cost a full pass over the dictionary
    initial begin
        #400_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold_cnt;
        out_ready = 1'b0;
        hold_cnt  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_go  = 1'b0;
                hold_cnt = 500;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ready <= 1'b0;
            end else if (gaps_on) begin
                out_ready <= ($urandom_range(99) >= 32);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic [7:0] pix, input logic last);
        if (gaps_on) begin
            while ($urandom_range(99) < 32) begin
                in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_valid <= 1'b1;
        in_word  <= '{pixel: pix, last_pixel: last};
        forever begin
            @(negedge i_clk);
            if (in_ready) break;
        end
        @(posedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        // the dictionary wipe may still be running
        repeat (8400) @(posedge i_clk);
    endtask

    task automatic set_depth(input logic [3:0] d);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= d;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic send_image(input int len, input bit narrow);
        logic [7:0] p;
        for (int k = 0; k < len; k++) begin
            p = narrow ? 8'($urandom_range(3)) : 8'($urandom);
            send_word(p, k == len - 1);
        end
    endtask

    initial begin
        logic [3:0] depth_list [12];
        depth_list = '{4'd8, 4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd15, 4'd6, 4'd4, 4'd9,
                       4'd7, 4'd8};
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        gaps_on  = 1'b0;
        hold_go  = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, depth at reset value
        send_word(8'h00, 1'b1);
        send_word(8'hff, 1'b1);
        send_word(8'h55, 1'b0);
        send_word(8'h55, 1'b1);
        for (int k = 0; k < 10; k++) send_word(8'haa, k == 9);
        send_word(8'hff, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b0);
        send_word(8'h00, 1'b1);
        // image abandoned by a depth write
        for (int k = 0; k < 5; k++) send_word(8'($urandom), 1'b0);
        set_depth(4'd1);
        send_word(8'hff, 1'b0);
        send_word(8'h02, 1'b1);

        gaps_on = 1'b1;
        for (int ph = 0; ph < 12; ph++) begin
            set_depth(depth_list[ph]);
            if (ph == 11) gaps_on = 1'b0;     // one stretch without gaps
            if (ph == 3) hold_go = 1'b1;
            for (int got = 0; got < 36; ) begin
                int len;
                len = ($urandom_range(9) == 0) ? $urandom_range(60) + 1
                                              : $urandom_range(12) + 1;
                send_image(len, $urandom_range(1));
                got += len;
            end
        end

        drain();
        if (err_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/gle_pkg.sv
rtl/gle_ctrl.sv
rtl/gle_datapath.sv
rtl/gif_lzw_encoder.sv
test/gle_checker.sv
test/tb_gif_lzw_encoder.sv
